// File: src/assert_macros.svh
// Assertion macros for the packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clock, masked while reset is high.
`define HSBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Next-cycle implication built on the check above.
`define HSBP_ASSERT_NEXT(label, ante, cons, msg) \
   `HSBP_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: src/hsbp_pkg.sv
// Shared types and constants for the Huffman symbol bit packer.
package hsbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;
   localparam int SYM_W        = $clog2(SYMBOL_COUNT);
   localparam int LEN_LIMIT    = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam int MAX_RESULTS  = 4;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Results produced by one input word, handed to the output buffer.
   typedef struct packed {
      logic [2:0]                    count;
      logic                          is_end;
      logic [MAX_RESULTS-1:0][7:0]   data_bytes;
      logic [31:0]                   total;
   } result_type;

endpackage

// File: src/hsbp_code_table.sv
// Code word and length table with per-entry valid bits and registered read.
module hsbp_code_table
   import hsbp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [SYM_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [SYM_W-1:0] wr_addr,
   input  logic [31:0]      wr_word,
   input  logic [5:0]       wr_len,
   output logic [31:0]      rd_word,
   output logic [5:0]       rd_len
);

   logic [31:0]             word_mem_ff [SYMBOL_COUNT];
   logic [5:0]              len_mem_ff  [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] valid_ff;
   logic [SYMBOL_COUNT-1:0] valid_in;
   logic [31:0]             rd_word_ff;
   logic [5:0]              rd_len_ff;
   logic                    rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem_ff[wr_addr] <= wr_word;
         len_mem_ff[wr_addr]  <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= word_mem_ff[rd_addr];
         rd_len_ff  <= len_mem_ff[rd_addr];
      end
   end

   // Unwritten entries read as an empty code.
   assign rd_word = rd_word_ff;
   assign rd_len  = rd_valid_ff ? rd_len_ff : 6'd0;

endmodule

// File: src/hsbp_packer.sv
// Lookup stage and bit accumulator: turns one word into its packed results.
module hsbp_packer
   import hsbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [1:0]  take_op,
   input  logic        take_in_range,
   input  logic [31:0] code_word,
   input  logic [5:0]  code_len,
   input  logic        buf_free,
   output logic        ready,
   output logic        push,
   output result_type  result
);

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff;
   logic        s1_range_ff;
   logic [6:0]  pend_ff, pend_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] coded_ff, coded_in;

   logic        is_encode;
   logic        is_flush;
   logic        go;
   logic [5:0]  len_eff;
   logic [32:0] word_mask;
   logic [38:0] merged;
   logic [5:0]  total_bits;
   logic [39:0] aligned;
   logic [7:0]  rem_mask;
   logic [6:0]  rem_bits;
   logic [32:0] coded_sum;
   logic [31:0] coded_sat;
   logic [7:0]  flush_byte;

   assign is_encode = s1_valid_ff && s1_range_ff && (s1_op_ff == OP_ENCODE);
   assign is_flush  = s1_valid_ff && (s1_op_ff == OP_FLUSH);

   assign len_eff    = is_encode ? code_len : 6'd0;
   assign word_mask  = (33'd1 << len_eff) - 33'd1;
   assign merged     = ({32'd0, pend_ff} << len_eff) | {7'd0, code_word & word_mask[31:0]};
   assign total_bits = {3'd0, cnt_ff} + len_eff;
   assign aligned    = {1'b0, merged} << (6'd40 - total_bits);
   assign rem_mask   = (8'd1 << total_bits[2:0]) - 8'd1;
   assign rem_bits   = merged[6:0] & rem_mask[6:0];
   assign coded_sum  = {1'b0, coded_ff} + {27'd0, len_eff};
   assign coded_sat  = coded_sum[32] ? 32'hFFFF_FFFF : coded_sum[31:0];
   assign flush_byte = {1'b0, pend_ff} << (4'd8 - {1'b0, cnt_ff});

   always_comb begin
      result = '0;
      if (is_encode) begin
         result.count  = total_bits[5:3];
         result.is_end = 1'b0;
         for (int k = 0; k < MAX_RESULTS; k++) begin
            result.data_bytes[k] = aligned[39 - 8*k -: 8];
         end
      end else if (is_flush) begin
         result.is_end = 1'b1;
         result.total  = coded_ff;
         if (cnt_ff != 3'd0) begin
            result.count         = 3'd2;
            result.data_bytes[0] = flush_byte;
         end else begin
            result.count = 3'd1;
         end
      end
   end

   assign go    = s1_valid_ff && (buf_free || (result.count == 3'd0));
   assign push  = go && (result.count != 3'd0);
   assign ready = !s1_valid_ff || go;

   always_comb begin
      s1_valid_in = take ? 1'b1 : (go ? 1'b0 : s1_valid_ff);
      pend_in     = pend_ff;
      cnt_in      = cnt_ff;
      coded_in    = coded_ff;
      if (go && is_encode) begin
         pend_in  = rem_bits;
         cnt_in   = total_bits[2:0];
         coded_in = coded_sat;
      end else if (go && is_flush) begin
         pend_in  = 7'd0;
         cnt_in   = 3'd0;
         coded_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pend_ff     <= 7'd0;
         cnt_ff      <= 3'd0;
         coded_ff    <= 32'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pend_ff     <= pend_in;
         cnt_ff      <= cnt_in;
         coded_ff    <= coded_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff    <= take_op;
         s1_range_ff <= take_in_range;
      end
   end

endmodule

// File: src/hsbp_out_buffer.sv
// Output buffer: holds the results of one word and drains them one per cycle while rsp_ready is high.
module hsbp_out_buffer
   import hsbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  result_type  result,
   output logic        buf_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [31:0] rsp_bit_total,
   output logic        rsp_last
);

`include "assert_macros.svh"

   logic [2:0]                  buf_n_ff, buf_n_in;
   logic [1:0]                  idx_ff, idx_in;
   logic                        end_ff;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff;
   logic [31:0]                 total_ff;
   logic                        is_last;
   logic                        fire;

   assign rsp_valid = (buf_n_ff != 3'd0);
   assign is_last   = ({1'b0, idx_ff} == (buf_n_ff - 3'd1));
   assign fire      = rsp_valid && rsp_ready;
   assign buf_free  = !rsp_valid || (rsp_ready && is_last);

   assign rsp_last      = is_last;
   assign rsp_kind      = (end_ff && is_last) ? KIND_END : KIND_DATA;
   assign rsp_data_byte = (rsp_kind == KIND_END) ? 8'd0 : bytes_ff[idx_ff];
   assign rsp_bit_total = (rsp_kind == KIND_END) ? total_ff : 32'd0;

   always_comb begin
      buf_n_in = buf_n_ff;
      idx_in   = idx_ff;
      if (push) begin
         buf_n_in = result.count;
         idx_in   = 2'd0;
      end else if (fire) begin
         if (is_last) begin
            buf_n_in = 3'd0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_n_ff <= 3'd0;
         idx_ff   <= 2'd0;
      end else begin
         buf_n_ff <= buf_n_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         bytes_ff <= result.data_bytes;
         end_ff   <= result.is_end;
         total_ff <= result.total;
      end
   end

   `HSBP_ASSERT(a_count_range, buf_n_ff <= 3'd4, "result count above four")
   `HSBP_ASSERT(a_idx_in_range, (buf_n_ff != 3'd0) |-> ({1'b0, idx_ff} < buf_n_ff), "index past count")
   `HSBP_ASSERT_NEXT(a_mid_word_advance, rsp_valid && rsp_ready && !rsp_last, (buf_n_ff == $past(buf_n_ff)) && (idx_ff == $past(idx_ff) + 2'd1), "buffer reloaded mid word")

endmodule

// File: src/huffman_symbol_bit_packer_unit.sv
// Huffman symbol bit packer: code table load, symbol encode and flush, byte-wide output.
// An input word can be accepted every cycle while each word causes at most one result
// and the output keeps draining; it passes through the table read register, then its
// packed results are registered in the output buffer. A load causes no result. An
// encode causes zero to four data bytes, a flush one data byte (if bits are pending)
// plus the end record; the byte-wide output buffer emits one result per cycle while
// rsp_ready is high. The table needs no clearing pass after reset.
module huffman_symbol_bit_packer_unit
   import hsbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_symbol,
   input  logic [31:0] req_code_bits,
   input  logic [5:0]  req_code_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [31:0] rsp_bit_total,
   output logic        rsp_last
);

   logic        accept;
   logic        in_range;
   logic [5:0]  load_len;
   logic [31:0] code_word;
   logic [5:0]  code_len;
   logic        buf_free;
   logic        push;
   result_type  result;

   assign accept   = req_valid && req_ready;
   assign in_range = ({1'b0, req_symbol} < 9'(SYMBOL_COUNT));
   assign load_len = (req_code_length > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT) : req_code_length;

   hsbp_code_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_symbol[SYM_W-1:0]),
      .wr_en   (accept && in_range && (req_op == OP_LOAD)),
      .wr_addr (req_symbol[SYM_W-1:0]),
      .wr_word (req_code_bits),
      .wr_len  (load_len),
      .rd_word (code_word),
      .rd_len  (code_len)
   );

   hsbp_packer u_packer (
      .clock         (clock),
      .reset         (reset),
      .take          (accept),
      .take_op       (req_op),
      .take_in_range (in_range),
      .code_word     (code_word),
      .code_len      (code_len),
      .buf_free      (buf_free),
      .ready         (req_ready),
      .push          (push),
      .result        (result)
   );

   hsbp_out_buffer u_out (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .result        (result),
      .buf_free      (buf_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_bit_total (rsp_bit_total),
      .rsp_last      (rsp_last)
   );

endmodule
